// ===== hdl/dmac4_pkg.sv =====
// ----------------------------------------------------------------------------
// dmac4_pkg
// Shared types and codes for the four-channel DMA controller.
// ----------------------------------------------------------------------------
package dmac4_pkg;

	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_READ  = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_DREQ  = 3'd3,
		CMD_HLDA  = 3'd4
	} cmd_t;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_S0   = 8'b0000_0010,
		ST_S1   = 8'b0000_0100,
		ST_S2   = 8'b0000_1000,
		ST_S3   = 8'b0001_0000,
		ST_S4   = 8'b0010_0000,
		ST_SC   = 8'b0100_0000,
		ST_S11  = 8'b1000_0000
	} cyc_state_t;

	localparam logic [1:0] OP_WRITE   = 2'b01;
	localparam logic [1:0] OP_READ    = 2'b10;
	localparam logic [1:0] OP_ILLEGAL = 2'b11;

	localparam logic [1:0] TM_DEMAND  = 2'b00;
	localparam logic [1:0] TM_SINGLE  = 2'b01;
	localparam logic [1:0] TM_BLOCK   = 2'b10;
	localparam logic [1:0] TM_CASCADE = 2'b11;

	localparam logic [3:0] REG_STATUS   = 4'd8;
	localparam logic [3:0] REG_REQUEST  = 4'd9;
	localparam logic [3:0] REG_MASK_BIT = 4'd10;
	localparam logic [3:0] REG_MODE     = 4'd11;
	localparam logic [3:0] REG_CLR_FF   = 4'd12;
	localparam logic [3:0] REG_TEMP     = 4'd13;
	localparam logic [3:0] REG_CLR_MASK = 4'd14;
	localparam logic [3:0] REG_ALL_MASK = 4'd15;

	// Bus actions of one transaction
	typedef struct packed {
		logic        mem_read;
		logic        mem_write;
		logic        io_read;
		logic        io_write;
		logic [1:0]  io_channel;
		logic [15:0] read_address;
		logic [15:0] write_address;
		logic [7:0]  write_data;
	} bus_act_t;

endpackage

// ===== hdl/dmac4_prio.sv =====
// ----------------------------------------------------------------------------
// dmac4_prio
// Fixed or rotating priority pick among pending channels.
// ----------------------------------------------------------------------------
module dmac4_prio (
	input  logic [3:0] pend,
	input  logic       rotate,
	input  logic [1:0] last,
	output logic [1:0] pick
);
	import dmac4_pkg::*;

	// scan from the start channel downward; the last hit wins
	always_comb begin
		logic [1:0] c;
		c = rotate ? last : 2'd3;
		pick = 2'd0;
		for (int i = 0; i < 4; i++) begin
			if (pend[c]) pick = c;
			c = c - 2'd1;
		end
	end

endmodule

// ===== hdl/dma_controller_four_channel.sv =====
// ----------------------------------------------------------------------------
// dma_controller_four_channel
// Four-channel DMA controller: register file, cycle states, priority.
// ----------------------------------------------------------------------------
//  channel   direction  ports
//  command   in         start, busy, cmd, reg_offset, wr_data, line_channel,
//                       line_level, bus_read_data
//  result    out        done, reg_read_data ... write_data
//
// One transaction per clock: start is sampled into an input register, and the
// result is registered from it, with done high for one cycle.
// busy is always low; the state update path is one pass of logic.
// arst_n clears all control state; address and count stores are not reset.
// The receiver cannot stall, so results are never held back.
module dma_controller_four_channel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [3:0]  reg_offset,
	input  logic [7:0]  wr_data,
	input  logic [1:0]  line_channel,
	input  logic        line_level,
	input  logic [7:0]  bus_read_data,
	output logic        done,
	output logic [7:0]  reg_read_data,
	output logic        hold_request,
	output logic        eop_level,
	output logic [3:0]  dack_levels,
	output logic        mem_read,
	output logic        mem_write,
	output logic        io_read,
	output logic        io_write,
	output logic [1:0]  io_channel,
	output logic [15:0] read_address,
	output logic [15:0] write_address,
	output logic [7:0]  write_data
);
	import dmac4_pkg::*;

	// input register
	logic       vld_s1;
	logic [2:0] cmd_s1;
	logic [3:0] off_s1;
	logic [7:0] wd_s1, bus_s1;
	logic [1:0] lch_s1;
	logic       lvl_s1;

	// architectural state
	cyc_state_t  st_q;
	logic [7:0]  command_q, status_q, mask_q, temp_q, held_q;
	logic [3:0]  req_q, dack_q, pagex_q;
	logic [7:0]  mode_q [4];
	logic [15:0] badr_q [4], cadr_q [4], bcnt_q [4], ccnt_q [4];
	logic        hreq_q, hack_q, eop_q, ff_q;
	logic [1:0]  svc_q, last_q;

	// next state
	cyc_state_t  st_d;
	logic [7:0]  command_d, status_d, mask_d, temp_d, held_d;
	logic [3:0]  req_d, dack_d, pagex_d;
	logic [7:0]  mode_d [4];
	logic [15:0] badr_d [4], cadr_d [4], bcnt_d [4], ccnt_d [4];
	logic        hreq_d, hack_d, eop_d, ff_d;
	logic [1:0]  svc_d, last_d;
	logic [7:0]  rd_d;
	bus_act_t    act;

	logic [3:0] pend;
	logic [1:0] pick;

	assign busy = 1'b0;

	always_comb begin
		logic [3:0] rq;
		rq   = command_q[6] ? ~req_q : req_q;
		pend = rq & ~mask_q[3:0];
	end

	dmac4_prio u_prio (
		.pend   (pend),
		.rotate (command_q[4]),
		.last   (last_q),
		.pick   (pick)
	);

	function automatic logic [3:0] dack_of(input logic pol, input logic en,
		input logic [1:0] ch);
		logic [3:0] lv;
		for (int i = 0; i < 4; i++)
			lv[i] = (en && ch == 2'(i)) ^ ~pol;
		return lv;
	endfunction

	// state update for one transaction
	always_comb begin
		logic [1:0]  ch, dc, op, tm;
		logic [7:0]  md;
		logic [15:0] v;
		logic        tc;
		ch = svc_q;
		md = mode_q[svc_q];
		op = md[3:2];
		tm = md[7:6];
		dc = wd_s1[1:0];
		v  = 16'd0;
		tc = 1'b0;
		st_d = st_q; command_d = command_q; status_d = status_q; mask_d = mask_q;
		temp_d = temp_q; held_d = held_q; req_d = req_q; dack_d = dack_q;
		pagex_d = pagex_q; hreq_d = hreq_q; hack_d = hack_q; eop_d = eop_q;
		ff_d = ff_q; svc_d = svc_q; last_d = last_q;
		for (int i = 0; i < 4; i++) begin
			mode_d[i] = mode_q[i]; badr_d[i] = badr_q[i]; cadr_d[i] = cadr_q[i];
			bcnt_d[i] = bcnt_q[i]; ccnt_d[i] = ccnt_q[i];
		end
		rd_d = 8'd0;
		act  = '0;
		if (vld_s1) begin
			case (cmd_s1)
				CMD_TICK: begin
					if (!command_q[2]) begin
						case (st_q)
							ST_IDLE: begin
								if (!eop_q) eop_d = 1'b1;
								if (pend != 4'd0) begin
									svc_d = pick; last_d = pick; hreq_d = 1'b1;
									st_d = ST_S0;
								end else if (command_q == 8'd3 && req_q[0]) begin
									hack_d = 1'b1; st_d = ST_S0;
								end
							end
							ST_S0: begin
								if (hack_q) begin
									if (tm == TM_CASCADE) begin
										dack_d = dack_of(command_q[7], 1'b1, ch);
										st_d = ST_SC;
									end else begin
										st_d = command_q[0] ? ST_S11 : ST_S1;
									end
								end
							end
							ST_SC: begin
								if (!req_q[ch]) begin
									hreq_d = 1'b0; hack_d = 1'b0; st_d = ST_IDLE;
									dack_d = dack_of(command_q[7], 1'b0, ch);
								end
								if (status_q[ch]) eop_d = 1'b0;
							end
							ST_S1: st_d = ST_S2;
							ST_S2: begin
								dack_d = dack_of(command_q[7], 1'b1, ch);
								st_d = command_q[3] ? ST_S4 : ST_S3;
							end
							ST_S3: begin
								if (op == OP_WRITE) begin
									held_d = bus_s1; act.io_read = 1'b1; act.io_channel = ch;
								end else if (op == OP_READ) begin
									held_d = bus_s1; act.mem_read = 1'b1;
									act.read_address = cadr_q[ch];
								end
								st_d = ST_S4;
							end
							ST_S4: begin
								if (command_q[3]) begin
									if (op == OP_WRITE) begin
										held_d = bus_s1; act.io_read = 1'b1;
										act.io_channel = ch;
									end else if (op == OP_READ) begin
										held_d = bus_s1; act.mem_read = 1'b1;
										act.read_address = cadr_q[ch];
									end
								end
								if (op == OP_WRITE) begin
									act.mem_write = 1'b1; act.write_address = cadr_q[ch];
									act.write_data = held_d;
								end else if (op == OP_READ) begin
									act.io_write = 1'b1; act.io_channel = ch;
									act.write_data = held_d;
								end
								// address/count step
								if (op != OP_ILLEGAL) begin
									pagex_d[ch] = 1'b0;
									if (md[5]) begin
										cadr_d[ch] = cadr_q[ch] - 16'd1;
										if (cadr_d[ch][7:0] == 8'hFF) pagex_d[ch] = 1'b1;
									end else begin
										cadr_d[ch] = cadr_q[ch] + 16'd1;
										if (cadr_d[ch][7:0] == 8'h00) pagex_d[ch] = 1'b1;
									end
									ccnt_d[ch] = ccnt_q[ch] - 16'd1;
									if (ccnt_d[ch] == 16'hFFFF) begin
										status_d[ch] = 1'b1;
										if (md[4]) begin
											cadr_d[ch] = badr_q[ch]; ccnt_d[ch] = bcnt_q[ch];
											pagex_d[ch] = 1'b1;
										end else begin
											mask_d[ch] = 1'b1;
										end
									end
								end
								tc = status_d[ch];
								case (tm)
									TM_DEMAND: begin
										if (tc || !eop_q || !req_q[ch]) begin
											hreq_d = 1'b0; hack_d = 1'b0; st_d = ST_IDLE;
										end else st_d = pagex_d[ch] ? ST_S1 : ST_S2;
									end
									TM_SINGLE: begin
										hreq_d = 1'b0; hack_d = 1'b0; st_d = ST_IDLE;
									end
									TM_BLOCK: begin
										if (tc || !eop_q) begin
											hreq_d = 1'b0; hack_d = 1'b0; st_d = ST_IDLE;
										end else st_d = pagex_d[ch] ? ST_S1 : ST_S2;
									end
									default: ;
								endcase
								if (tc) eop_d = 1'b0;
								if (st_d == ST_IDLE) dack_d = dack_of(command_q[7], 1'b0, ch);
							end
							default: begin
								// memory to memory, channel 0 to channel 1
								held_d = bus_s1;
								act.mem_read = 1'b1; act.read_address = cadr_q[0];
								act.mem_write = 1'b1; act.write_address = cadr_q[1];
								act.write_data = bus_s1;
								svc_d = 2'd0;
								if (mode_q[0][3:2] != OP_ILLEGAL) begin
									pagex_d[0] = 1'b0;
									if (mode_q[0][5]) begin
										cadr_d[0] = cadr_q[0] - 16'd1;
										if (cadr_d[0][7:0] == 8'hFF) pagex_d[0] = 1'b1;
									end else begin
										cadr_d[0] = cadr_q[0] + 16'd1;
										if (cadr_d[0][7:0] == 8'h00) pagex_d[0] = 1'b1;
									end
									ccnt_d[0] = ccnt_q[0] - 16'd1;
									if (ccnt_d[0] == 16'hFFFF) begin
										status_d[0] = 1'b1;
										if (mode_q[0][4]) begin
											cadr_d[0] = badr_q[0]; ccnt_d[0] = bcnt_q[0];
											pagex_d[0] = 1'b1;
										end else begin
											mask_d[0] = 1'b1;
										end
									end
								end
								ccnt_d[1] = ccnt_d[1] - 16'd1;
								cadr_d[1] = cadr_d[1] + 16'd1;
								if (ccnt_d[0] == 16'hFFFF || ccnt_d[1] == 16'hFFFF) begin
									hreq_d = 1'b0; hack_d = 1'b0; st_d = ST_IDLE;
									status_d[1:0] = 2'b11;
									req_d[1:0] = 2'b00;
								end
							end
						endcase
					end
				end
				CMD_READ: begin
					rd_d = 8'hFF;
					if (!off_s1[3]) begin
						v = off_s1[0] ? ccnt_q[off_s1[2:1]] : cadr_q[off_s1[2:1]];
						rd_d = ff_q ? v[15:8] : v[7:0];
						ff_d = ~ff_q;
					end else if (off_s1 == REG_STATUS) begin
						rd_d = status_q; status_d = status_q & 8'hF0;
					end else if (off_s1 == REG_MASK_BIT) begin
						rd_d = mask_q;
					end else if (off_s1 == REG_TEMP) begin
						rd_d = temp_q;
					end
				end
				CMD_WRITE: begin
					if (!off_s1[3]) begin
						if (off_s1[0]) begin
							if (ff_q) begin
								bcnt_d[off_s1[2:1]][15:8] = wd_s1;
								ccnt_d[off_s1[2:1]][15:8] = wd_s1;
							end else begin
								bcnt_d[off_s1[2:1]][7:0] = wd_s1;
								ccnt_d[off_s1[2:1]][7:0] = wd_s1;
							end
						end else begin
							if (ff_q) begin
								badr_d[off_s1[2:1]][15:8] = wd_s1;
								cadr_d[off_s1[2:1]][15:8] = wd_s1;
							end else begin
								badr_d[off_s1[2:1]][7:0] = wd_s1;
								cadr_d[off_s1[2:1]][7:0] = wd_s1;
							end
						end
						ff_d = ~ff_q;
					end else begin
						case (off_s1)
							REG_STATUS: command_d = wd_s1;
							REG_REQUEST: begin
								if (wd_s1[2]) req_d[dc] = 1'b1;
								else begin
									status_d[3'd4 + 3'(dc)] = 1'b0;
									req_d[dc] = 1'b0;
								end
							end
							REG_MASK_BIT: begin
								mask_d[dc] = wd_s1[2];
								mask_d[3'd4 + 3'(dc)] = wd_s1[2];
							end
							REG_MODE: begin
								mode_d[dc] = wd_s1; status_d[dc] = 1'b0;
							end
							REG_CLR_FF: begin
								temp_d = wd_s1; ff_d = 1'b0;
							end
							REG_TEMP: begin
								ff_d = 1'b0; mask_d = 8'h0F; st_d = ST_IDLE;
								status_d = status_q & 8'hF0; temp_d = 8'd0;
							end
							REG_CLR_MASK: mask_d = 8'd0;
							default: mask_d = {4'd0, wd_s1[3:0]};
						endcase
					end
				end
				CMD_DREQ: req_d[lch_s1] = lvl_s1;
				CMD_HLDA: hack_d = lvl_s1;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd; off_s1 <= reg_offset; wd_s1 <= wr_data;
		lch_s1 <= line_channel; lvl_s1 <= line_level; bus_s1 <= bus_read_data;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; command_q <= 8'd0; status_q <= 8'h0F; mask_q <= 8'd0;
			temp_q <= 8'd0; req_q <= 4'd0; dack_q <= 4'hF; pagex_q <= 4'd0;
			hreq_q <= 1'b0; hack_q <= 1'b0; eop_q <= 1'b1; ff_q <= 1'b0;
			svc_q <= 2'd0; last_q <= 2'd3;
			for (int i = 0; i < 4; i++) mode_q[i] <= 8'd0;
		end else begin
			st_q <= st_d; command_q <= command_d; status_q <= status_d;
			mask_q <= mask_d; temp_q <= temp_d; req_q <= req_d; dack_q <= dack_d;
			pagex_q <= pagex_d; hreq_q <= hreq_d; hack_q <= hack_d; eop_q <= eop_d;
			ff_q <= ff_d; svc_q <= svc_d; last_q <= last_d;
			for (int i = 0; i < 4; i++) mode_q[i] <= mode_d[i];
		end
	end

	// address and count stores, undefined until written
	always_ff @(posedge clk) begin
		held_q <= held_d;
		for (int i = 0; i < 4; i++) begin
			badr_q[i] <= badr_d[i]; cadr_q[i] <= cadr_d[i];
			bcnt_q[i] <= bcnt_d[i]; ccnt_q[i] <= ccnt_d[i];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vld_s1;
	end

	always_ff @(posedge clk) begin
		reg_read_data <= rd_d;
		hold_request  <= hreq_d;
		eop_level     <= eop_d;
		dack_levels   <= dack_d;
		mem_read      <= act.mem_read;
		mem_write     <= act.mem_write;
		io_read       <= act.io_read;
		io_write      <= act.io_write;
		io_channel    <= act.io_channel;
		read_address  <= act.read_address;
		write_address <= act.write_address;
		write_data    <= act.write_data;
	end

	// each accepted transaction gives exactly one result, through the input and result registers
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##2 done) else $error("result missing");
	a_nodone: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##2 !done) else $error("spurious result");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q)) else $error("cycle state not one-hot");

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-channel DMA controller. A driver feeds
// queued transactions (ticks, register accesses, line changes) with random
// idle bursts. A cycle-exact predictor computes the expected result of each
// accepted transaction. A monitor compares every done cycle against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import dmac4_pkg::*;

	// One queued command transaction
	typedef struct {
		logic [2:0] cmd;
		logic [3:0] off;
		logic [7:0] data;
		logic [1:0] lch;
		logic       lvl;
		logic [7:0] bus;
	} dma_txn_t;

	// Expected result of one transaction
	typedef struct {
		logic [7:0]  rd;
		logic        hr;
		logic        eop;
		logic [3:0]  dack;
		bus_act_t    act;
	} dma_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  cmd;
	logic [3:0]  reg_offset;
	logic [7:0]  wr_data;
	logic [1:0]  line_channel;
	logic        line_level;
	logic [7:0]  bus_read_data;
	logic        done;
	logic [7:0]  reg_read_data;
	logic        hold_request;
	logic        eop_level;
	logic [3:0]  dack_levels;
	logic        mem_read;
	logic        mem_write;
	logic        io_read;
	logic        io_write;
	logic [1:0]  io_channel;
	logic [15:0] read_address;
	logic [15:0] write_address;
	logic [7:0]  write_data;

	dma_controller_four_channel u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.reg_offset(reg_offset), .wr_data(wr_data), .line_channel(line_channel),
		.line_level(line_level), .bus_read_data(bus_read_data), .done(done),
		.reg_read_data(reg_read_data), .hold_request(hold_request),
		.eop_level(eop_level), .dack_levels(dack_levels), .mem_read(mem_read),
		.mem_write(mem_write), .io_read(io_read), .io_write(io_write),
		.io_channel(io_channel), .read_address(read_address),
		.write_address(write_address), .write_data(write_data)
	);

	dma_txn_t    pending_txns[$];
	dma_result_t expected_results[$];
	int          error_count = 0;

	// ------------------------------------------------------------------
	// Controller shadow state
	// ------------------------------------------------------------------
	cyc_state_t  cs;
	logic [7:0]  cmd_reg, status, mask, temp, held;
	logic [3:0]  req_lines, dack;
	logic [7:0]  modes [4];
	logic        page_x [4];
	logic [15:0] base_a [4], cur_a [4], base_c [4], cur_c [4];
	logic        hreq, hack, eop, ff;
	logic [1:0]  svc, last_svc;
	bus_act_t    act;

	initial begin
		cs = ST_IDLE; cmd_reg = 0; status = 8'h0F; mask = 0; req_lines = 0;
		hreq = 0; hack = 0; eop = 1; svc = 0; last_svc = 3; ff = 0;
		temp = 0; held = 0; dack = 4'hF;
		for (int i = 0; i < 4; i++) begin
			modes[i] = 0; page_x[i] = 0;
			base_a[i] = 0; cur_a[i] = 0; base_c[i] = 0; cur_c[i] = 0;
		end
	end

	function automatic void set_dack(int ch);
		for (int i = 0; i < 4; i++)
			dack[i] = (i == ch) ^ !cmd_reg[7];
	endfunction

	function automatic void fetch_byte(logic [7:0] b);
		logic [1:0] op;
		op = modes[svc][3:2];
		if (op == OP_WRITE) begin
			held = b; act.io_read = 1; act.io_channel = svc;
		end else if (op == OP_READ) begin
			held = b; act.mem_read = 1; act.read_address = cur_a[svc];
		end
	endfunction

	function automatic void store_byte();
		logic [1:0] op;
		op = modes[svc][3:2];
		if (op == OP_WRITE) begin
			act.mem_write = 1; act.write_address = cur_a[svc]; act.write_data = held;
		end else if (op == OP_READ) begin
			act.io_write = 1; act.io_channel = svc; act.write_data = held;
		end
	endfunction

	// Address/count step with terminal count and auto-init
	function automatic void advance_channel();
		logic [1:0] ch;
		logic [7:0] m;
		ch = svc;
		m = modes[ch];
		if (m[3:2] == OP_ILLEGAL) return;
		page_x[ch] = 0;
		if (m[5]) begin
			cur_a[ch] = cur_a[ch] - 16'd1;
			if (cur_a[ch][7:0] == 8'hFF) page_x[ch] = 1;
		end else begin
			cur_a[ch] = cur_a[ch] + 16'd1;
			if (cur_a[ch][7:0] == 8'h00) page_x[ch] = 1;
		end
		cur_c[ch] = cur_c[ch] - 16'd1;
		if (cur_c[ch] == 16'hFFFF) begin
			status[ch] = 1;
			if (m[4]) begin
				cur_a[ch] = base_a[ch]; cur_c[ch] = base_c[ch]; page_x[ch] = 1;
			end else begin
				mask[ch] = 1;
			end
		end
	endfunction

	function automatic void release_bus();
		hreq = 0; hack = 0; cs = ST_IDLE;
	endfunction

	function automatic void clock_tick(logic [7:0] b);
		logic [1:0] ch, c, pick, tm;
		logic [3:0] rq, pend;
		logic       tc;
		ch = svc;
		if (cmd_reg[2]) return;
		case (cs)
			ST_IDLE: begin
				rq = cmd_reg[6] ? ~req_lines : req_lines;
				pend = rq & ~mask[3:0];
				if (!eop) eop = 1;
				if (pend != 0) begin
					c = cmd_reg[4] ? last_svc : 2'd3;
					pick = 0;
					for (int i = 0; i < 4; i++) begin
						if (pend[c]) pick = c;
						c = c - 2'd1;
					end
					svc = pick; last_svc = pick; hreq = 1; cs = ST_S0;
				end else if (cmd_reg == 8'd3 && req_lines[0]) begin
					hack = 1; cs = ST_S0;
				end
			end
			ST_S0: begin
				if (hack) begin
					if (modes[ch][7:6] == TM_CASCADE) begin
						set_dack(ch); cs = ST_SC;
					end else begin
						cs = cmd_reg[0] ? ST_S11 : ST_S1;
					end
				end
			end
			ST_SC: begin
				if (!req_lines[ch]) begin
					release_bus(); set_dack(-1);
				end
				if (status[ch]) eop = 0;
			end
			ST_S1: cs = ST_S2;
			ST_S2: begin
				set_dack(ch);
				cs = cmd_reg[3] ? ST_S4 : ST_S3;
			end
			ST_S3: begin
				fetch_byte(b); cs = ST_S4;
			end
			ST_S4: begin
				if (cmd_reg[3]) fetch_byte(b);
				store_byte();
				advance_channel();
				tm = modes[ch][7:6];
				tc = status[ch];
				if (tm == TM_DEMAND) begin
					if (tc || !eop || !req_lines[ch]) release_bus();
					else cs = page_x[ch] ? ST_S1 : ST_S2;
				end else if (tm == TM_SINGLE) begin
					release_bus();
				end else if (tm == TM_BLOCK) begin
					if (tc || !eop) release_bus();
					else cs = page_x[ch] ? ST_S1 : ST_S2;
				end
				if (status[ch]) eop = 0;
				if (cs == ST_IDLE) set_dack(-1);
			end
			default: begin
				// memory-to-memory copy, channel 0 source, channel 1 target
				held = b;
				act.mem_read = 1; act.read_address = cur_a[0];
				act.mem_write = 1; act.write_address = cur_a[1]; act.write_data = b;
				svc = 0;
				advance_channel();
				cur_c[1] = cur_c[1] - 16'd1;
				cur_a[1] = cur_a[1] + 16'd1;
				if (cur_c[0] == 16'hFFFF || cur_c[1] == 16'hFFFF) begin
					release_bus();
					status[1:0] = 2'b11;
					req_lines[1:0] = 2'b00;
				end
			end
		endcase
	endfunction

	function automatic logic [7:0] read_register(logic [3:0] off);
		logic [7:0]  d;
		logic [15:0] v;
		d = 8'hFF;
		if (off < REG_STATUS) begin
			v = off[0] ? cur_c[off[2:1]] : cur_a[off[2:1]];
			d = ff ? v[15:8] : v[7:0];
			ff = !ff;
		end else if (off == REG_STATUS) begin
			d = status; status = status & 8'hF0;
		end else if (off == REG_MASK_BIT) begin
			d = mask;
		end else if (off == REG_TEMP) begin
			d = temp;
		end
		return d;
	endfunction

	function automatic void write_register(logic [3:0] off, logic [7:0] d);
		logic [1:0] ch, dc;
		ch = off[2:1];
		dc = d[1:0];
		if (off < REG_STATUS) begin
			if (off[0]) begin
				if (ff) begin base_c[ch][15:8] = d; cur_c[ch][15:8] = d; end
				else begin base_c[ch][7:0] = d; cur_c[ch][7:0] = d; end
			end else begin
				if (ff) begin base_a[ch][15:8] = d; cur_a[ch][15:8] = d; end
				else begin base_a[ch][7:0] = d; cur_a[ch][7:0] = d; end
			end
			ff = !ff;
			return;
		end
		case (off)
			REG_STATUS: cmd_reg = d;
			REG_REQUEST: begin
				if (d[2]) req_lines[dc] = 1;
				else begin
					status[4 + dc] = 0; req_lines[dc] = 0;
				end
			end
			REG_MASK_BIT: begin
				mask[dc] = d[2]; mask[4 + dc] = d[2];
			end
			REG_MODE: begin
				modes[dc] = d; status[dc] = 0;
			end
			REG_CLR_FF: begin
				temp = d; ff = 0;
			end
			REG_TEMP: begin
				ff = 0; mask = 8'h0F; cs = ST_IDLE; status = status & 8'hF0; temp = 0;
			end
			REG_CLR_MASK: mask = 0;
			default: mask = {4'h0, d[3:0]};
		endcase
	endfunction

	// Expected result of one accepted transaction
	function automatic dma_result_t predict_result(dma_txn_t t);
		dma_result_t r;
		logic [7:0]  rd;
		rd = 0;
		act = '0;
		case (t.cmd)
			CMD_TICK:  clock_tick(t.bus);
			CMD_READ:  rd = read_register(t.off);
			CMD_WRITE: write_register(t.off, t.data);
			CMD_DREQ:  req_lines[t.lch] = t.lvl;
			CMD_HLDA:  hack = t.lvl;
			default: ;
		endcase
		r.rd = rd; r.hr = hreq; r.eop = eop; r.dack = dack; r.act = act;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	task automatic push(logic [2:0] c, logic [3:0] o, logic [7:0] d,
			logic [1:0] l, logic v);
		dma_txn_t t;
		t.cmd = c; t.off = o; t.data = d; t.lch = l; t.lvl = v;
		t.bus = 8'($urandom);
		pending_txns.push_back(t);
	endtask

	task automatic reg_wr(logic [3:0] o, logic [7:0] d);
		push(CMD_WRITE, o, d, 2'($urandom), 1'($urandom));
	endtask

	task automatic reg_rd(logic [3:0] o);
		push(CMD_READ, o, 8'($urandom), 2'($urandom), 1'($urandom));
	endtask

	task automatic ticks(int n);
		repeat (n) push(CMD_TICK, 4'($urandom), 8'($urandom), 2'($urandom), 1'($urandom));
	endtask

	task automatic dreq(logic [1:0] ch, logic v);
		push(CMD_DREQ, 4'($urandom), 8'($urandom), ch, v);
	endtask

	task automatic hlda(logic v);
		push(CMD_HLDA, 4'($urandom), 8'($urandom), 2'($urandom), v);
	endtask

	// Load address and count of one channel; counts stay short mostly
	task automatic load_channel(logic [1:0] ch, logic [15:0] addr, logic [15:0] cnt);
		reg_wr(REG_CLR_FF, 8'($urandom));
		reg_wr({1'b0, ch, 1'b0}, addr[7:0]);
		reg_wr({1'b0, ch, 1'b0}, addr[15:8]);
		reg_wr({1'b0, ch, 1'b1}, cnt[7:0]);
		reg_wr({1'b0, ch, 1'b1}, cnt[15:8]);
	endtask

	function automatic logic [15:0] short_count();
		if ($urandom_range(0, 19) == 0) return 16'($urandom_range(0, 300));
		return 16'($urandom_range(0, 5));
	endfunction

	task automatic channel_transfer();
		logic [1:0] ch;
		logic [7:0] c;
		int         n;
		ch = 2'($urandom);
		if ($urandom_range(0, 9) < 7) begin
			c = {1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
				1'($urandom), ($urandom_range(0, 9) == 0), 2'b00};
			if ($urandom_range(0, 14) == 0) c = 8'($urandom);
			reg_wr(REG_STATUS, c);
		end
		// address near a page boundary now and then
		load_channel(ch, $urandom_range(0, 3) == 0 ? {8'($urandom), 8'hFE} : 16'($urandom),
			short_count());
		reg_wr(REG_MODE, {8'($urandom)} & 8'hFC | ch);
		reg_wr(REG_MASK_BIT, {5'($urandom), 1'b0, ch});
		if ($urandom_range(0, 1)) dreq(ch, 1);
		else reg_wr(REG_REQUEST, {5'($urandom), 1'b1, ch});
		ticks(2);
		hlda(1);
		n = $urandom_range(6, 40);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 19))
				0: dreq(ch, 0);
				1: reg_rd(4'($urandom));
				2: dreq(2'($urandom), 1'($urandom));
				3: hlda(1);
				default: ticks(1);
			endcase
		end
		dreq(ch, 0);
		ticks($urandom_range(1, 4));
		hlda(0);
		if ($urandom_range(0, 2) == 0) reg_rd(REG_STATUS);
	endtask

	task automatic mem_copy();
		load_channel(0, 16'($urandom), short_count());
		load_channel(1, 16'($urandom), short_count());
		reg_wr(REG_STATUS, 8'd3);
		reg_wr(REG_MASK_BIT, 8'h04);
		reg_wr(REG_REQUEST, 8'h04);
		ticks($urandom_range(10, 30));
		reg_wr(REG_STATUS, 8'd0);
		reg_wr(REG_CLR_MASK, 8'($urandom));
		hlda(0);
	endtask

	task automatic noise();
		repeat ($urandom_range(1, 6))
			push(3'($urandom), 4'($urandom), 8'($urandom), 2'($urandom), 1'($urandom));
	endtask

	initial begin
		// Directed: define all address/count stores, then one read transfer
		// so the held byte is defined before any store can use it.
		reg_wr(REG_CLR_FF, 8'h00);
		for (int ch = 0; ch < 4; ch++) begin
			reg_wr({1'b0, 2'(ch), 1'b0}, ch == 0 ? 8'hFF : 8'h00);
			reg_wr({1'b0, 2'(ch), 1'b0}, ch == 0 ? 8'hFF : 8'h00);
			reg_wr({1'b0, 2'(ch), 1'b1}, 8'h01);
			reg_wr({1'b0, 2'(ch), 1'b1}, 8'h00);
		end
		reg_wr(REG_MODE, 8'h48);
		dreq(0, 1);
		ticks(1);
		hlda(1);
		ticks(5);
		reg_rd(REG_STATUS);
		reg_rd(4'd0);
		reg_rd(REG_TEMP);
		push(3'd7, 4'hF, 8'hFF, 2'd3, 1'b1);
		reg_wr(REG_TEMP, 8'hFF);
		reg_rd(REG_ALL_MASK);
		// Random: mostly well-formed transfers
		while (pending_txns.size() < 1480) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: channel_transfer();
				6: mem_copy();
				default: noise();
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------
	initial begin
		clk = 0;
		forever #5 clk = !clk;
	end

	initial begin
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
	end

	// ------------------------------------------------------------------
	// Driver
	// ------------------------------------------------------------------
	int       idle_left;
	dma_txn_t cur_txn;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0; cmd <= 0; reg_offset <= 0; wr_data <= 0;
			line_channel <= 0; line_level <= 0; bus_read_data <= 0;
			idle_left <= 0;
		end else begin
			if (start && !busy)
				expected_results.push_back(predict_result(cur_txn));
			if (start && busy) begin
				// hold the transaction
			end else if (idle_left > 0) begin
				idle_left <= idle_left - 1;
				start <= 0;
			end else if (pending_txns.size() > 0) begin
				if (pending_txns.size() > 150 && $urandom_range(0, 15) == 0) begin
					idle_left <= $urandom_range(0, 10);
					start <= 0;
				end else begin
					cur_txn <= pending_txns[0];
					cmd <= pending_txns[0].cmd;
					reg_offset <= pending_txns[0].off;
					wr_data <= pending_txns[0].data;
					line_channel <= pending_txns[0].lch;
					line_level <= pending_txns[0].lvl;
					bus_read_data <= pending_txns[0].bus;
					void'(pending_txns.pop_front());
					start <= 1;
				end
			end else begin
				start <= 0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor
	// ------------------------------------------------------------------
	task automatic report(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
		if (got !== want) report(what, got, want);
	endtask

	always @(posedge clk) begin
		dma_result_t e;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report("unexpected result", 16'h0, 16'h0);
			end else begin
				e = expected_results.pop_front();
				check_field("reg_read_data", 16'(reg_read_data), 16'(e.rd));
				check_field("hold_request", 16'(hold_request), 16'(e.hr));
				check_field("eop_level", 16'(eop_level), 16'(e.eop));
				check_field("dack_levels", 16'(dack_levels), 16'(e.dack));
				check_field("mem_read", 16'(mem_read), 16'(e.act.mem_read));
				check_field("mem_write", 16'(mem_write), 16'(e.act.mem_write));
				check_field("io_read", 16'(io_read), 16'(e.act.io_read));
				check_field("io_write", 16'(io_write), 16'(e.act.io_write));
				check_field("io_channel", 16'(io_channel), 16'(e.act.io_channel));
				check_field("read_address", read_address, e.act.read_address);
				check_field("write_address", write_address, e.act.write_address);
				check_field("write_data", 16'(write_data), 16'(e.act.write_data));
			end
		end
	end

	// ------------------------------------------------------------------
	// End of run
	// ------------------------------------------------------------------
	initial begin
		@(posedge arst_n);
		do @(posedge clk);
		while (pending_txns.size() != 0 || start || expected_results.size() != 0);
		repeat (5) @(posedge clk);
		if (expected_results.size() != 0)
			report("results missing", 16'(expected_results.size()), 16'h0);
		if (error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#5ms;
		$display("testbench: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/dmac4_pkg.sv
hdl/dmac4_prio.sv
hdl/dma_controller_four_channel.sv
verif/testbench.sv
